### hw/rtl/ccvr_pkg.sv
// ---------------------------------------------------------------------------
// ccvr_pkg
// Shared types and constants of the character cell video raster.
// ---------------------------------------------------------------------------
package ccvr_pkg;

   // field widths
   localparam int OPCODE_W    = 2;
   localparam int VRAM_ADDR_W = 13;
   localparam int BYTE_W      = 8;
   localparam int COLOUR_W    = 3;
   localparam int TSTATE_W    = 17;
   localparam int OFFSET_W    = 17;
   localparam int PIXELS_W    = 32;
   localparam int NIBBLE_W    = 4;

   // screen memory layout
   localparam int BITMAP_BYTES = 6144;
   localparam int ATTR_BYTES   = 768;
   localparam int SCREEN_BYTES = BITMAP_BYTES + ATTR_BYTES;
   localparam int BMP_AW       = $clog2(BITMAP_BYTES);
   localparam int ATTR_AW      = $clog2(ATTR_BYTES);
   localparam int CELL_X_W     = 5;
   localparam int CELL_Y_W     = 8;

   // raster geometry
   localparam int TSTATES_PER_CELL   = 4;
   localparam int PIXELS_PER_CELL    = 8;
   localparam int TOP_VISIBLE_LINE   = 16;
   localparam int PAPER_FIRST_LINE   = 64;
   localparam int PAPER_END_LINE     = 256;
   localparam int BOTTOM_END_LINE    = 312;
   localparam int LEFT_BORDER_END    = 24;
   localparam int RIGHT_BORDER_START = 152;
   localparam int RIGHT_BORDER_END   = 176;
   localparam int BUS_WINDOW_END     = 128;

   // attribute byte
   localparam int ATTR_FLASH_BIT  = 7;
   localparam int ATTR_BRIGHT_BIT = 6;

   localparam logic [BYTE_W-1:0] IDLE_BUS = 8'hFF;

   // defaults of the top level parameters
   localparam int DEF_TSTATES_PER_LINE = 224;
   localparam int DEF_LINES_PER_FRAME  = 312;

   // reciprocal scaling for the line divide
   localparam int RECIP_SHIFT = 25;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE       = 2'd0,
      OP_TICK        = 2'd1,
      OP_FRAME_RESET = 2'd2,
      OP_BUS_READ    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      JOB_WR_BITMAP  = 3'd0,
      JOB_WR_ATTR    = 3'd1,
      JOB_BORDER     = 3'd2,
      JOB_PAPER      = 3'd3,
      JOB_BUS_BITMAP = 3'd4,
      JOB_BUS_ATTR   = 3'd5,
      JOB_BUS_IDLE   = 3'd6
   } job_kind_type;

   localparam logic RESULT_PIXELS = 1'b0;
   localparam logic RESULT_BUS    = 1'b1;

   typedef struct packed {
      job_kind_type          kind;
      logic [BMP_AW-1:0]     bmp_addr;
      logic [ATTR_AW-1:0]    attr_addr;
      logic [BYTE_W-1:0]     data;
      logic [COLOUR_W-1:0]   border;
      logic                  flash;
      logic [OFFSET_W-1:0]   offset;
   } job_type;

endpackage

### hw/rtl/ccvr_ram.sv
// ---------------------------------------------------------------------------
// ccvr_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module ccvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ccvr_queue.sv
// ---------------------------------------------------------------------------
// ccvr_queue
// Small job queue between the decode front and the memory back end.
// ---------------------------------------------------------------------------
module ccvr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ccvr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output ccvr_pkg::job_type pop_job,
   output logic              empty
);

   localparam int DEPTH = ccvr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ccvr_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");

endmodule

### hw/rtl/ccvr_front.sv
// ---------------------------------------------------------------------------
// ccvr_front
// Accepts items, tracks the raster position and turns each item that needs
// one into a memory job: addresses, colours and framebuffer offset.
// ---------------------------------------------------------------------------
module ccvr_front #(
   parameter int TSTATES_PER_LINE = ccvr_pkg::DEF_TSTATES_PER_LINE,
   parameter int LINES_PER_FRAME  = ccvr_pkg::DEF_LINES_PER_FRAME
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ccvr_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [ccvr_pkg::VRAM_ADDR_W-1:0]     req_vram_address,
   input  logic [ccvr_pkg::BYTE_W-1:0]          req_vram_data,
   input  logic [ccvr_pkg::COLOUR_W-1:0]        req_border_colour,
   input  logic                                 req_flash_phase,
   input  logic [ccvr_pkg::TSTATE_W-1:0]        req_cpu_tstate,
   input  logic                                 clearing,
   input  logic                                 q_full,
   output logic                                 q_push,
   output ccvr_pkg::job_type                    q_job
);

   localparam int TSTATE_W = ccvr_pkg::TSTATE_W;
   localparam int LINE_W   = $clog2(LINES_PER_FRAME + 1);
   localparam int TS_W     = $clog2(TSTATES_PER_LINE);
   localparam int RECIP    = (1 << ccvr_pkg::RECIP_SHIFT) / TSTATES_PER_LINE;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int PROD_W   = TSTATE_W + RECIP_W;
   localparam int QUOT_W   = $clog2((((1 << TSTATE_W) - 1) / TSTATES_PER_LINE) + 2);
   localparam int X_W      = ccvr_pkg::CELL_X_W;
   localparam int Y_W      = ccvr_pkg::CELL_Y_W;

   // accept stage
   logic                                  s1_valid_ff, s1_valid_in;
   ccvr_pkg::opcode_type                  s1_op_ff;
   logic [ccvr_pkg::VRAM_ADDR_W-1:0]      s1_addr_ff;
   logic [ccvr_pkg::BYTE_W-1:0]           s1_data_ff;
   logic [ccvr_pkg::COLOUR_W-1:0]         s1_border_ff;
   logic                                  s1_flash_ff;
   logic [TSTATE_W-1:0]                   s1_cpu_ts_ff;
   logic [PROD_W-1:0]                     s1_prod_ff, s1_prod_in;

   // raster position
   logic [TS_W-1:0]                       pos_ts_ff, pos_ts_in;
   logic [LINE_W-1:0]                     pos_line_ff, pos_line_in;
   logic [ccvr_pkg::OFFSET_W-1:0]         index_ff, index_in;

   logic                                  accept;
   logic                                  advance;
   logic                                  push_need;
   ccvr_pkg::job_type                     job;

   // floating bus divide
   logic [QUOT_W-1:0]                     q_est;
   logic [TSTATE_W-1:0]                   rem_est;
   logic [QUOT_W-1:0]                     bus_line;
   logic [TS_W-1:0]                       bus_ts;
   logic [Y_W-1:0]                        bus_y;
   logic [X_W-1:0]                        bus_x;
   logic                                  bus_window;

   // tick
   logic                                  tick_live;
   logic                                  tick_retrace;
   logic                                  tick_paper;
   logic [Y_W-1:0]                        tick_y;
   logic [X_W-1:0]                        tick_x;
   logic [TS_W:0]                         ts_sum;

   assign accept     = req_valid && req_ready;
   assign s1_prod_in = PROD_W'(req_cpu_tstate) * PROD_W'(RECIP);

   // quotient estimate is low by at most one
   always_comb begin
      q_est   = QUOT_W'(s1_prod_ff >> ccvr_pkg::RECIP_SHIFT);
      rem_est = s1_cpu_ts_ff - TSTATE_W'(q_est * TSTATES_PER_LINE);
      if (rem_est >= TSTATE_W'(TSTATES_PER_LINE)) begin
         bus_line = QUOT_W'(q_est + 1'b1);
         bus_ts   = TS_W'(rem_est - TSTATE_W'(TSTATES_PER_LINE));
      end else begin
         bus_line = q_est;
         bus_ts   = TS_W'(rem_est);
      end
      bus_window = (bus_line >= QUOT_W'(ccvr_pkg::PAPER_FIRST_LINE)) &&
                   (bus_line < QUOT_W'(ccvr_pkg::PAPER_END_LINE)) &&
                   (bus_ts < TS_W'(ccvr_pkg::BUS_WINDOW_END));
      bus_y = Y_W'(bus_line - QUOT_W'(ccvr_pkg::PAPER_FIRST_LINE));
      bus_x = X_W'(bus_ts >> 2);
   end

   always_comb begin
      tick_live    = (pos_line_ff < LINE_W'(LINES_PER_FRAME));
      tick_retrace = (pos_line_ff < LINE_W'(ccvr_pkg::TOP_VISIBLE_LINE)) ||
                     (pos_line_ff >= LINE_W'(ccvr_pkg::BOTTOM_END_LINE)) ||
                     (pos_ts_ff >= TS_W'(ccvr_pkg::RIGHT_BORDER_END));
      tick_paper   = (pos_line_ff >= LINE_W'(ccvr_pkg::PAPER_FIRST_LINE)) &&
                     (pos_line_ff < LINE_W'(ccvr_pkg::PAPER_END_LINE)) &&
                     (pos_ts_ff >= TS_W'(ccvr_pkg::LEFT_BORDER_END)) &&
                     (pos_ts_ff < TS_W'(ccvr_pkg::RIGHT_BORDER_START));
      tick_y = Y_W'(pos_line_ff - LINE_W'(ccvr_pkg::PAPER_FIRST_LINE));
      tick_x = X_W'((pos_ts_ff >> 2) -
               TS_W'(ccvr_pkg::LEFT_BORDER_END / ccvr_pkg::TSTATES_PER_CELL));
      ts_sum = (TS_W + 1)'(pos_ts_ff) + (TS_W + 1)'(ccvr_pkg::TSTATES_PER_CELL);
   end

   // job decode
   always_comb begin
      job        = '0;
      job.data   = s1_data_ff;
      job.border = s1_border_ff;
      job.flash  = s1_flash_ff;
      job.offset = index_ff;
      push_need  = 1'b0;
      unique case (s1_op_ff)
         ccvr_pkg::OP_WRITE: begin
            if (s1_addr_ff < ccvr_pkg::VRAM_ADDR_W'(ccvr_pkg::BITMAP_BYTES)) begin
               job.kind     = ccvr_pkg::JOB_WR_BITMAP;
               job.bmp_addr = ccvr_pkg::BMP_AW'(s1_addr_ff);
               push_need    = 1'b1;
            end else if (s1_addr_ff <
                         ccvr_pkg::VRAM_ADDR_W'(ccvr_pkg::SCREEN_BYTES)) begin
               job.kind      = ccvr_pkg::JOB_WR_ATTR;
               job.attr_addr = ccvr_pkg::ATTR_AW'(s1_addr_ff -
                               ccvr_pkg::VRAM_ADDR_W'(ccvr_pkg::BITMAP_BYTES));
               push_need     = 1'b1;
            end
         end
         ccvr_pkg::OP_TICK: begin
            job.kind      = tick_paper ? ccvr_pkg::JOB_PAPER : ccvr_pkg::JOB_BORDER;
            job.bmp_addr  = {tick_y[7:6], tick_y[2:0], tick_y[5:3], tick_x};
            job.attr_addr = {tick_y[7:3], tick_x};
            push_need     = tick_live && !tick_retrace;
         end
         ccvr_pkg::OP_FRAME_RESET: begin
            push_need = 1'b0;
         end
         ccvr_pkg::OP_BUS_READ: begin
            job.bmp_addr  = {bus_y[7:6], bus_y[2:0], bus_y[5:3], bus_x};
            job.attr_addr = {bus_y[7:3], bus_x};
            push_need     = 1'b1;
            // attribute fetch on phases 3 and 5, bitmap on 2 and 4, idle bus otherwise
            if (bus_window && (bus_ts[2:0] == 3'd3 || bus_ts[2:0] == 3'd5)) begin
               job.kind = ccvr_pkg::JOB_BUS_ATTR;
            end else if (bus_window && (bus_ts[2:0] == 3'd2 || bus_ts[2:0] == 3'd4)) begin
               job.kind = ccvr_pkg::JOB_BUS_BITMAP;
            end else begin
               job.kind = ccvr_pkg::JOB_BUS_IDLE;
            end
         end
      endcase
   end

   assign advance   = s1_valid_ff && (!push_need || !q_full);
   assign q_push    = s1_valid_ff && push_need && !q_full;
   assign q_job     = job;
   assign req_ready = !clearing && (!s1_valid_ff || advance);

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      pos_ts_in   = pos_ts_ff;
      pos_line_in = pos_line_ff;
      index_in    = index_ff;
      if (advance) begin
         priority if (s1_op_ff == ccvr_pkg::OP_FRAME_RESET) begin
            pos_ts_in   = '0;
            pos_line_in = '0;
            index_in    = '0;
         end else if (s1_op_ff == ccvr_pkg::OP_TICK && tick_live) begin
            if (ts_sum >= (TS_W + 1)'(TSTATES_PER_LINE)) begin
               pos_ts_in   = TS_W'(ts_sum - (TS_W + 1)'(TSTATES_PER_LINE));
               pos_line_in = LINE_W'(pos_line_ff + 1'b1);
            end else begin
               pos_ts_in = TS_W'(ts_sum);
            end
            if (!tick_retrace) begin
               index_in = ccvr_pkg::OFFSET_W'(index_ff +
                          ccvr_pkg::OFFSET_W'(ccvr_pkg::PIXELS_PER_CELL));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ts_ff   <= '0;
         pos_line_ff <= '0;
         index_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ts_ff   <= pos_ts_in;
         pos_line_ff <= pos_line_in;
         index_ff    <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= ccvr_pkg::opcode_type'(req_opcode);
         s1_addr_ff   <= req_vram_address;
         s1_data_ff   <= req_vram_data;
         s1_border_ff <= req_border_colour;
         s1_flash_ff  <= req_flash_phase;
         s1_cpu_ts_ff <= req_cpu_tstate;
         s1_prod_ff   <= s1_prod_in;
      end
   end

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      (pos_line_ff <= LINE_W'(LINES_PER_FRAME)) &&
      ((TS_W + 1)'(pos_ts_ff) < (TS_W + 1)'(TSTATES_PER_LINE)))
      else $error("raster position out of frame");

endmodule

### hw/rtl/ccvr_back.sv
// ---------------------------------------------------------------------------
// ccvr_back
// Owns the screen memory: clears it after reset, performs writes and
// fetches, and formats pixel and floating bus results.
// ---------------------------------------------------------------------------
module ccvr_back (
   input  logic                               clock,
   input  logic                               reset,
   output logic                               clearing,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  ccvr_pkg::job_type                  q_job,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_result_kind,
   output logic [ccvr_pkg::OFFSET_W-1:0]      rsp_pixel_offset,
   output logic [ccvr_pkg::PIXELS_W-1:0]      rsp_pixel_indices,
   output logic [ccvr_pkg::BYTE_W-1:0]        rsp_bus_data
);

   localparam int BMP_AW  = ccvr_pkg::BMP_AW;
   localparam int ATTR_AW = ccvr_pkg::ATTR_AW;
   localparam int BYTE_W  = ccvr_pkg::BYTE_W;

   logic                  clearing_ff, clearing_in;
   logic [BMP_AW-1:0]     clr_addr_ff, clr_addr_in;

   logic                  bmp_wr_en;
   logic [BMP_AW-1:0]     bmp_wr_addr;
   logic [BYTE_W-1:0]     bmp_wr_data;
   logic [BYTE_W-1:0]     bmp_rd_data;
   logic                  attr_wr_en;
   logic [ATTR_AW-1:0]    attr_wr_addr;
   logic [BYTE_W-1:0]     attr_wr_data;
   logic [BYTE_W-1:0]     attr_rd_data;

   logic                  out_free;
   logic                  is_fetch;

   // fetch stage: item whose memory data is on the read ports
   logic                           s1_valid_ff, s1_valid_in;
   ccvr_pkg::job_kind_type         s1_kind_ff;
   logic [ccvr_pkg::COLOUR_W-1:0]  s1_border_ff;
   logic                           s1_flash_ff;
   logic [ccvr_pkg::OFFSET_W-1:0]  s1_offset_ff;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [ccvr_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [ccvr_pkg::PIXELS_W-1:0]  rsp_pixels_ff, rsp_pixels_in;
   logic [BYTE_W-1:0]              rsp_bus_ff, rsp_bus_in;

   logic [ccvr_pkg::COLOUR_W-1:0]  ink;
   logic [ccvr_pkg::COLOUR_W-1:0]  paper;

   assign clearing = clearing_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = !clearing_ff && !q_empty && (!s1_valid_ff || out_free);
   assign is_fetch = (q_job.kind != ccvr_pkg::JOB_WR_BITMAP) &&
                     (q_job.kind != ccvr_pkg::JOB_WR_ATTR);

   // clear sweep covers the bitmap, the attribute area rides along
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = BMP_AW'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == BMP_AW'(ccvr_pkg::BITMAP_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         bmp_wr_en    = 1'b1;
         bmp_wr_addr  = clr_addr_ff;
         bmp_wr_data  = '0;
         attr_wr_en   = (clr_addr_ff < BMP_AW'(ccvr_pkg::ATTR_BYTES));
         attr_wr_addr = ATTR_AW'(clr_addr_ff);
         attr_wr_data = '0;
      end else begin
         bmp_wr_en    = q_pop && (q_job.kind == ccvr_pkg::JOB_WR_BITMAP);
         bmp_wr_addr  = q_job.bmp_addr;
         bmp_wr_data  = q_job.data;
         attr_wr_en   = q_pop && (q_job.kind == ccvr_pkg::JOB_WR_ATTR);
         attr_wr_addr = q_job.attr_addr;
         attr_wr_data = q_job.data;
      end
   end

   ccvr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ccvr_pkg::BITMAP_BYTES)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bmp_wr_en),
      .wr_addr (bmp_wr_addr),
      .wr_data (bmp_wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_job.bmp_addr),
      .rd_data (bmp_rd_data)
   );

   ccvr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ccvr_pkg::ATTR_BYTES)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_wr_en),
      .wr_addr (attr_wr_addr),
      .wr_data (attr_wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_job.attr_addr),
      .rd_data (attr_rd_data)
   );

   always_comb begin
      s1_valid_in = q_pop ? is_fetch : (out_free ? 1'b0 : s1_valid_ff);
   end

   // result formatting
   always_comb begin
      ink   = attr_rd_data[2:0];
      paper = attr_rd_data[5:3];
      if (attr_rd_data[ccvr_pkg::ATTR_FLASH_BIT] && s1_flash_ff) begin
         ink   = attr_rd_data[5:3];
         paper = attr_rd_data[2:0];
      end
      rsp_kind_in   = ccvr_pkg::RESULT_PIXELS;
      rsp_offset_in = s1_offset_ff;
      rsp_pixels_in = '0;
      rsp_bus_in    = ccvr_pkg::IDLE_BUS;
      unique case (s1_kind_ff)
         ccvr_pkg::JOB_BORDER: begin
            rsp_pixels_in = {ccvr_pkg::PIXELS_PER_CELL{1'b0, s1_border_ff}};
         end
         ccvr_pkg::JOB_PAPER: begin
            // leftmost pixel is bit 7, top nibble
            for (int i = 0; i < ccvr_pkg::PIXELS_PER_CELL; i++) begin
               rsp_pixels_in[i*ccvr_pkg::NIBBLE_W +: ccvr_pkg::NIBBLE_W] =
                  {attr_rd_data[ccvr_pkg::ATTR_BRIGHT_BIT],
                   bmp_rd_data[i] ? ink : paper};
            end
         end
         ccvr_pkg::JOB_BUS_BITMAP: begin
            rsp_kind_in   = ccvr_pkg::RESULT_BUS;
            rsp_offset_in = '0;
            rsp_bus_in    = bmp_rd_data;
         end
         ccvr_pkg::JOB_BUS_ATTR: begin
            rsp_kind_in   = ccvr_pkg::RESULT_BUS;
            rsp_offset_in = '0;
            rsp_bus_in    = attr_rd_data;
         end
         ccvr_pkg::JOB_BUS_IDLE: begin
            rsp_kind_in   = ccvr_pkg::RESULT_BUS;
            rsp_offset_in = '0;
         end
         default: begin
            rsp_offset_in = '0;
         end
      endcase
      rsp_valid_in = (s1_valid_ff && out_free) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_kind_ff   <= q_job.kind;
         s1_border_ff <= q_job.border;
         s1_flash_ff  <= q_job.flash;
         s1_offset_ff <= q_job.offset;
      end
      if (s1_valid_ff && out_free) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_pixels_ff <= rsp_pixels_in;
         rsp_bus_ff    <= rsp_bus_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_pixel_offset  = rsp_offset_ff;
   assign rsp_pixel_indices = rsp_pixels_ff;
   assign rsp_bus_data      = rsp_bus_ff;

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !q_pop)
      else $error("job taken during memory clear");

   a_fetch_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> ($stable(bmp_rd_data) && $stable(attr_rd_data)))
      else $error("fetched data lost while stalled");

endmodule

### hw/rtl/character_cell_video_raster.sv
// ---------------------------------------------------------------------------
// character_cell_video_raster
// Character cell video raster with screen memory and floating bus reads.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while req_ready is high (it is low in the
// clear and while a full job queue holds the front): a front stage decodes
// each item and tracks the raster position, a four-entry job queue
// decouples it from the back end, which does one screen memory access per
// cycle unless rsp_ready holds it (bitmap and attribute banks read in
// parallel) and formats the result, via its fetch stage into the rsp_
// output register. After reset a sweep clears the 6144 bitmap bytes, one a
// cycle, and the 768 attribute bytes beside the first of them, while req_ready stays low.
module character_cell_video_raster #(
   parameter int TSTATES_PER_LINE = ccvr_pkg::DEF_TSTATES_PER_LINE,
   parameter int LINES_PER_FRAME  = ccvr_pkg::DEF_LINES_PER_FRAME
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ccvr_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [ccvr_pkg::VRAM_ADDR_W-1:0]   req_vram_address,
   input  logic [ccvr_pkg::BYTE_W-1:0]        req_vram_data,
   input  logic [ccvr_pkg::COLOUR_W-1:0]      req_border_colour,
   input  logic                               req_flash_phase,
   input  logic [ccvr_pkg::TSTATE_W-1:0]      req_cpu_tstate,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_result_kind,
   output logic [ccvr_pkg::OFFSET_W-1:0]      rsp_pixel_offset,
   output logic [ccvr_pkg::PIXELS_W-1:0]      rsp_pixel_indices,
   output logic [ccvr_pkg::BYTE_W-1:0]        rsp_bus_data
);

   logic              clearing;
   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   ccvr_pkg::job_type push_job;
   ccvr_pkg::job_type pop_job;

   ccvr_front #(
      .TSTATES_PER_LINE (TSTATES_PER_LINE),
      .LINES_PER_FRAME  (LINES_PER_FRAME)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_vram_address  (req_vram_address),
      .req_vram_data     (req_vram_data),
      .req_border_colour (req_border_colour),
      .req_flash_phase   (req_flash_phase),
      .req_cpu_tstate    (req_cpu_tstate),
      .clearing          (clearing),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   ccvr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   ccvr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .clearing          (clearing),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_job             (pop_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_pixel_offset  (rsp_pixel_offset),
      .rsp_pixel_indices (rsp_pixel_indices),
      .rsp_bus_data      (rsp_bus_data)
   );

endmodule
